### rtl/core/gbba_pkg.sv
package gbba_pkg;

  // Default geometry
  localparam int GBBA_GROUPS      = 4;
  localparam int GBBA_GROUP_SIZE  = 256;
  localparam int GBBA_MAX_REQUEST = 16;

  // Bitmap word layout: block 8*w+j sits at bit 7-j of word w
  localparam int WORD_BITS = 8;
  localparam int IDX_W     = 3;
  localparam logic [WORD_BITS-1:0] TOP_BIT   = 8'h80;
  localparam logic [WORD_BITS-1:0] WORD_ONES = 8'hFF;

  // Field widths
  localparam int FUNC_W  = 1;
  localparam int PREF_W  = 2;
  localparam int COUNT_W = 5;
  localparam int BLK_W   = 10;
  localparam int STAT_W  = 2;

  // Request codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_PARTIAL = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE    = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADFREE = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [PREF_W-1:0]  preferred_group;
    logic [COUNT_W-1:0] request_count;
    logic [BLK_W-1:0]   block_to_free;
  } in_item_t;

  typedef struct packed {
    logic [BLK_W-1:0]  block_number;
    logic              last;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Result of the per-word free-bit search
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_FREE,
    S_FLUSH
  } state_t;

endpackage

### rtl/core/gbba_ram.sv
module gbba_ram import gbba_pkg::*; #(
  parameter int WIDTH = WORD_BITS,
  parameter int DEPTH = 128
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/gbba_pick.sv
module gbba_pick import gbba_pkg::*; #(
  parameter int ADDR_W = 7
) (
  input  logic [WORD_BITS-1:0] word,
  input  logic [ADDR_W-1:0]    word_addr,
  input  logic [ADDR_W+3:0]    lo,
  input  logic [ADDR_W+3:0]    hi,
  output pick_t                pick
);

  localparam int PW = ADDR_W + 4;

  // Lowest-numbered free block of the word that lies in [lo, hi)
  always_comb begin
    logic [PW-1:0] blk;
    pick = '0;
    blk  = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      blk = PW'({word_addr, IDX_W'(j)});
      if (!word[WORD_BITS-1-j] && (blk >= lo) && (blk < hi)) begin
        pick.found = 1'b1;
        pick.idx   = IDX_W'(j);
      end
    end
  end

endmodule

### rtl/core/grouped_block_bitmap_allocator.sv
// Grouped first-fit block allocator.
// Input channel (in_valid/in_stall/in_data) takes one request beat: an
// allocate of request_count blocks with a preferred group, or a free of one
// block. Output channel (out_valid/out_stall/out_data) gives one beat per
// claimed block, the final one marked last, or a single ST_NONE beat if none is
// claimed; a free gives exactly one beat. Only one request is in flight;
// in_stall stays high until its final beat has been loaded into the output
// register.
// An allocate walks the bitmap through a single search unit, one 8-bit word
// per cycle when no block is claimed from it and the output does not stall.
// A group whose free count is zero is left after its first word.
// Reset: the bitmap RAM is cleared by a pass of one word per cycle;
// in_stall is high during it and group counts are reset at once.
// Output stall: a waiting beat holds in the output register; the search
// pauses only when it has another claimed block to hand over.
module grouped_block_bitmap_allocator import gbba_pkg::*; #(
  parameter int GROUPS      = GBBA_GROUPS,
  parameter int GROUP_SIZE  = GBBA_GROUP_SIZE,
  parameter int MAX_REQUEST = GBBA_MAX_REQUEST
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int TOTAL = GROUPS * GROUP_SIZE;
  localparam int WORDS = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PW    = AW + 4;
  localparam int VW    = (PW > BLK_W) ? PW : BLK_W;
  localparam int CW    = $clog2(GROUP_SIZE + 1);
  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int GCW   = $clog2(GROUPS + 1);
  localparam int XW    = (GCW > PREF_W) ? GCW : PREF_W;
  localparam int WW    = $clog2(MAX_REQUEST + 1);

  function automatic logic [PW-1:0] grp_base(input logic [GCW-1:0] g);
    grp_base = PW'(g) * PW'(GROUP_SIZE);
  endfunction

  function automatic logic [AW-1:0] grp_word(input logic [GCW-1:0] g);
    logic [PW-1:0] b;
    b = grp_base(g);
    grp_word = b[AW+2:3];
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0]        clr_r, clr_nxt;
  logic [AW-1:0]        addr_r, addr_nxt;
  logic [WORD_BITS-1:0] wd_r, wd_nxt;
  logic                 fresh_r, fresh_nxt;
  logic                 dirty_r, dirty_nxt;
  logic [GW-1:0]        grp_r, grp_nxt;
  logic                 in_pref_r, in_pref_nxt;
  logic                 has_pref_r, has_pref_nxt;
  logic [PREF_W-1:0]    pref_r, pref_nxt;
  logic [WW-1:0]        want_r, want_nxt;
  logic [WW-1:0]        got_r, got_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [BLK_W-1:0]     pend_r, pend_nxt;
  logic [BLK_W-1:0]     vic_r, vic_nxt;
  logic [CW-1:0]        fcnt_r [GROUPS];
  logic                 out_v_r;
  out_item_t            out_r;

  // RAM port signals
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [WORD_BITS-1:0] wr_data, rd_data;

  // Output register control
  logic      out_load;
  out_item_t out_nxt;
  logic      out_free;

  // Request decode
  logic            in_take;
  logic            has_pref_in;
  logic [GCW-1:0]  first_grp;
  logic [WW-1:0]   want_sat;
  logic [VW-1:0]   vic_in_ext, vic_ext;

  // Scan datapath
  logic [WORD_BITS-1:0] word_cur;
  logic [PW-1:0]        base_cur, end_cur;
  logic                 last_word;
  logic [CW-1:0]        fcnt_cur;
  pick_t                pick;
  logic                 can_claim, claim_go, scan_exit;
  logic                 grp_done, all_done;
  logic [GCW-1:0]       cand_a, cand;
  logic                 cand_end;
  logic [AW-1:0]        next_addr;

  // Free datapath
  logic                 vic_in_range, vic_used, vic_ok;
  logic [WORD_BITS-1:0] free_mask;
  logic [GW-1:0]        vgrp;

  gbba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gbba_pick #(
    .ADDR_W (AW)
  ) u_pick (
    .word      (word_cur),
    .word_addr (addr_r),
    .lo        (base_cur),
    .hi        (end_cur),
    .pick      (pick)
  );

  // Request decode
  assign in_take     = in_valid && (state_r == S_IDLE);
  assign has_pref_in = 32'(in_data.preferred_group) < GROUPS;
  assign first_grp   = has_pref_in ? GCW'(in_data.preferred_group) : '0;
  assign want_sat    = (32'(in_data.request_count) > MAX_REQUEST) ? WW'(MAX_REQUEST)
                                                                  : WW'(in_data.request_count);
  assign vic_in_ext  = VW'(in_data.block_to_free);

  // Current word and group window
  assign word_cur  = fresh_r ? rd_data : wd_r;
  assign base_cur  = grp_base(GCW'(grp_r));
  assign end_cur   = base_cur + PW'(GROUP_SIZE);
  assign last_word = (PW'({addr_r, {IDX_W{1'b0}}}) + PW'(WORD_BITS)) >= end_cur;
  assign fcnt_cur  = fcnt_r[grp_r];

  // Claim one block per cycle while the output can take the previous claim, leave the word when nothing more fits
  assign can_claim = (state_r == S_SCAN) && pick.found && (got_r != want_r) &&
                     (fcnt_cur != '0);
  assign claim_go  = can_claim && (!pend_v_r || out_free);
  assign scan_exit = (state_r == S_SCAN) && !can_claim;
  assign grp_done  = (got_r == want_r) || (fcnt_cur == '0) || last_word;

  // Group order: preferred first, then ascending with the preferred skipped
  always_comb begin
    cand_a = in_pref_r ? '0 : GCW'(grp_r) + GCW'(1);
    cand   = cand_a;
    if (has_pref_r && (XW'(cand_a) == XW'(pref_r))) begin
      cand = cand_a + GCW'(1);
    end
  end

  assign cand_end  = 32'(cand) >= GROUPS;
  assign all_done  = (got_r == want_r) || (grp_done && cand_end);
  assign next_addr = grp_done ? grp_word(cand) : addr_r + AW'(1);

  // Free checks
  assign vic_ext      = VW'(vic_r);
  assign vic_in_range = vic_ext < VW'(TOTAL);
  assign vic_used     = rd_data[~vic_r[IDX_W-1:0]];
  assign vic_ok       = vic_in_range && vic_used;
  assign free_mask    = TOP_BIT >> vic_r[IDX_W-1:0];

  // Group of the block being freed
  always_comb begin
    logic [VW-1:0] lo;
    vgrp = '0;
    lo   = '0;
    for (int g = 0; g < GROUPS; g++) begin
      lo = VW'(g) * VW'(GROUP_SIZE);
      if ((vic_ext >= lo) && (vic_ext < lo + VW'(GROUP_SIZE))) begin
        vgrp = vgrp | GW'(g);
      end
    end
  end

  assign out_free = !out_v_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_r == AW'(WORDS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          if (in_data.func == FUNC_FREE) state_nxt = S_FREE;
          else if (want_sat == '0)       state_nxt = S_FLUSH;
          else                           state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_exit && all_done) state_nxt = S_FLUSH;
      end
      S_FREE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      S_FLUSH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, RAM ports, result beat
  always_comb begin
    in_stall = 1'b1;
    wr_en    = 1'b0;
    wr_addr  = addr_r;
    wr_data  = word_cur;
    rd_en    = 1'b0;
    rd_addr  = next_addr;
    out_load = 1'b0;
    out_nxt  = '{block_number: pend_r, last: 1'b0, status: ST_OK};
    unique case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '0;
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          rd_en   = 1'b1;
          rd_addr = (in_data.func == FUNC_FREE) ? vic_in_ext[AW+2:3] : grp_word(first_grp);
        end
      end
      S_SCAN: begin
        // hand over the previous claim when a new one is made
        if (claim_go && pend_v_r) begin
          out_load = 1'b1;
        end
        if (scan_exit) begin
          wr_en = dirty_r;
          rd_en = !all_done;
        end
      end
      S_FREE: begin
        wr_addr = vic_ext[AW+2:3];
        wr_data = rd_data & (WORD_ONES ^ free_mask);
        out_nxt = '{block_number: vic_r, last: 1'b1,
                    status: vic_ok ? ST_OK : ST_BADFREE};
        if (out_free) begin
          out_load = 1'b1;
          wr_en    = vic_ok;
        end
      end
      S_FLUSH: begin
        if (pend_v_r) begin
          out_nxt = '{block_number: pend_r, last: 1'b1,
                      status: (got_r < want_r) ? ST_PARTIAL : ST_OK};
        end else begin
          out_nxt = '{block_number: '0, last: 1'b1, status: ST_NONE};
        end
        out_load = out_free;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_nxt      = clr_r;
    addr_nxt     = addr_r;
    wd_nxt       = wd_r;
    fresh_nxt    = fresh_r;
    dirty_nxt    = dirty_r;
    grp_nxt      = grp_r;
    in_pref_nxt  = in_pref_r;
    has_pref_nxt = has_pref_r;
    pref_nxt     = pref_r;
    want_nxt     = want_r;
    got_nxt      = got_r;
    pend_v_nxt   = pend_v_r;
    pend_nxt     = pend_r;
    vic_nxt      = vic_r;
    if (state_r == S_CLEAR) begin
      clr_nxt = clr_r + AW'(1);
    end
    if (in_take) begin
      vic_nxt      = in_data.block_to_free;
      want_nxt     = want_sat;
      got_nxt      = '0;
      pend_v_nxt   = 1'b0;
      dirty_nxt    = 1'b0;
      fresh_nxt    = 1'b1;
      grp_nxt      = GW'(first_grp);
      in_pref_nxt  = has_pref_in;
      has_pref_nxt = has_pref_in;
      pref_nxt     = in_data.preferred_group;
      addr_nxt     = grp_word(first_grp);
    end
    if (claim_go) begin
      wd_nxt     = word_cur | (TOP_BIT >> pick.idx);
      dirty_nxt  = 1'b1;
      fresh_nxt  = 1'b0;
      got_nxt    = got_r + WW'(1);
      pend_v_nxt = 1'b1;
      pend_nxt   = BLK_W'(PW'({addr_r, pick.idx}));
    end
    if (scan_exit) begin
      // keep the word locally when the next group starts in the same word
      wd_nxt    = word_cur;
      dirty_nxt = 1'b0;
      fresh_nxt = (next_addr != addr_r);
      addr_nxt  = next_addr;
      if (grp_done) begin
        grp_nxt     = GW'(cand);
        in_pref_nxt = 1'b0;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      clr_r    <= '0;
      fresh_r  <= 1'b0;
      dirty_r  <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      fresh_r  <= fresh_nxt;
      dirty_r  <= dirty_nxt;
      pend_v_r <= pend_v_nxt;
      if (out_load)       out_v_r <= 1'b1;
      else if (!out_stall) out_v_r <= 1'b0;
    end
  end

  // Per-group free counts
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GROUPS; g++) begin
        fcnt_r[g] <= CW'(GROUP_SIZE);
      end
    end else if (claim_go) begin
      fcnt_r[grp_r] <= fcnt_cur - CW'(1);
    end else if ((state_r == S_FREE) && out_free && vic_ok) begin
      fcnt_r[vgrp] <= fcnt_r[vgrp] + CW'(1);
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    wd_r       <= wd_nxt;
    grp_r      <= grp_nxt;
    in_pref_r  <= in_pref_nxt;
    has_pref_r <= has_pref_nxt;
    pref_r     <= pref_nxt;
    want_r     <= want_nxt;
    got_r      <= got_nxt;
    pend_r     <= pend_nxt;
    vic_r      <= vic_nxt;
    if (out_load) out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

### rtl/core/gbba_checker.sv
module gbba_checker import gbba_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  // One request at a time: an accepted beat blocks the next cycle
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  // A none-free result is a single zero beat that closes the request
  a_none_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NONE) |->
      out_data.last && (out_data.block_number == '0))
    else $error("bad none-free beat");

  // Only the closing beat carries a non-ok status
  a_mid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == ST_OK)
    else $error("non-final beat with error status");

endmodule

bind grouped_block_bitmap_allocator gbba_checker u_gbba_checker (.*);
